[rtl/bfa_pkg.sv]
package bfa_pkg;

    // Fixed field widths of the request and result beats.
    localparam int OP_W    = 1;
    localparam int PID_W   = 4;
    localparam int BYTES_W = 16;
    localparam int UB_W    = 13;
    localparam int CODE_W  = 2;
    localparam int START_W = 6;
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Restoring divider takes one quotient bit per cycle.
    localparam int DIV_STEPS = BYTES_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [1:0]        t_pstat;

    localparam t_op OP_ALLOC = 1'b0;
    localparam t_op OP_FREE  = 1'b1;

    localparam t_code RC_DONE   = 2'd0;
    localparam t_code RC_NOFIT  = 2'd1;
    localparam t_code RC_STATUS = 2'd2;

    localparam t_pstat ST_PENDING   = 2'd0;
    localparam t_pstat ST_ALLOCATED = 2'd1;
    localparam t_pstat ST_FINISHED  = 2'd2;

    // Register map, index of the word.
    localparam logic REG_UNIT_BYTES = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_STAT,
        S_CHECK,
        S_DIV,
        S_FIT,
        S_SCAN,
        S_PICK,
        S_MARK,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   clr_step;
        logic   load;
        logic   div_init;
        logic   div_step;
        logic   pass_init;
        logic   scan_en;
        logic   sweep_en;
        logic   take_fit;
        logic   mark_step;
        logic   stat_we;
        t_pstat stat_val;
        logic   code_we;
        t_code  code;
    } t_cmd;

    typedef struct packed {
        logic   clr_last;
        t_op    op;
        logic   pid_ok;
        t_pstat stat;
        logic   div_last;
        logic   too_big;
        logic   pass_last;
        logic   found;
        logic   need_zero;
        logic   mark_last;
    } t_sts;

endpackage

[rtl/bfa_ctrl.sv]
module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import bfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STAT;
                end
            end
            S_STAT: begin
                // The status memory is read with the loaded r_pid; its registered word r_stat_q is ready in S_CHECK.
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.code_we = 1'b1;
                o_cmd.code    = RC_STATUS;
                n_state       = S_DONE;
                if (i_sts.pid_ok) begin
                    if (i_sts.op == OP_ALLOC && i_sts.stat == ST_PENDING) begin
                        o_cmd.code_we  = 1'b0;
                        o_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end else if (i_sts.op == OP_FREE && i_sts.stat == ST_ALLOCATED) begin
                        o_cmd.code      = RC_DONE;
                        o_cmd.stat_we   = 1'b1;
                        o_cmd.stat_val  = ST_FINISHED;
                        o_cmd.pass_init = 1'b1;
                        n_state         = S_FREE;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (i_sts.too_big) begin
                    o_cmd.code_we = 1'b1;
                    o_cmd.code    = RC_NOFIT;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.pass_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.pass_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.code_we = 1'b1;
                if (!i_sts.found) begin
                    o_cmd.code = RC_NOFIT;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.code     = RC_DONE;
                    o_cmd.take_fit = 1'b1;
                    o_cmd.stat_we  = 1'b1;
                    o_cmd.stat_val = ST_ALLOCATED;
                    n_state        = i_sts.need_zero ? S_DONE : S_MARK;
                end
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                o_cmd.sweep_en = 1'b1;
                if (i_sts.pass_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/bfa_dp.sv]
module bfa_dp #(
    parameter int UNITS = 64,
    parameter int PROCS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfa_pkg::t_cmd                 i_cmd,
    output bfa_pkg::t_sts                 o_sts,
    input  logic [bfa_pkg::UB_W-1:0]      i_unit_bytes,
    input  bfa_pkg::t_op                  i_operation,
    input  logic [bfa_pkg::PID_W-1:0]     i_process_id,
    input  logic [bfa_pkg::BYTES_W-1:0]   i_request_bytes,
    output bfa_pkg::t_code                o_result_code,
    output logic [bfa_pkg::START_W-1:0]   o_start_unit,
    output logic [bfa_pkg::COUNT_W-1:0]   o_unit_count
);
    import bfa_pkg::*;

    localparam int AW    = $clog2(UNITS);
    localparam int PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int LW    = $clog2(UNITS + 2);
    localparam int CLR_N = (UNITS > PROCS) ? UNITS : PROCS;
    localparam int CLW   = $clog2(CLR_N);

    // Unit memory word: used flag on top, owner below.
    logic [PID_W:0] r_umem [UNITS];
    t_pstat         r_smem [PROCS];

    logic [CLW-1:0]     r_clr;
    t_op                r_op;
    logic [PID_W-1:0]   r_pid;
    logic [BYTES_W-1:0] r_dvd;
    logic [UB_W-1:0]    r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [LW-1:0]      r_need;
    logic               r_too_big;
    logic [AW-1:0]      r_addr;
    logic               r_iss;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic [PID_W:0]     r_rd_q;
    t_pstat             r_stat_q;
    logic [LW-1:0]      r_cur_len;
    logic [AW-1:0]      r_cur_start;
    logic [LW-1:0]      r_best_len;
    logic [AW-1:0]      r_best_start;
    logic               r_found;
    logic [AW-1:0]      r_waddr;
    logic [LW-1:0]      r_k;
    t_code              r_code;
    logic [AW-1:0]      r_start;
    logic [LW-1:0]      r_count;

    logic [PW+PID_W-1:0] pid_ext;
    logic [PW-1:0]       pid_idx;
    logic                pid_ok;
    logic [UB_W-1:0]     divisor;
    logic [UB_W:0]       div_sh;
    logic                div_ge;
    logic [UB_W:0]       div_diff;
    logic                rd_free;
    logic                rd_last;
    logic [LW-1:0]       len_now;
    logic [AW-1:0]       start_now;
    logic                run_close;
    logic                run_fits;
    logic                sweep_hit;
    logic                clr_unit;
    logic                clr_proc;
    logic                u_we;
    logic [AW-1:0]       u_waddr;
    logic [PID_W:0]      u_wdata;
    logic                s_we;
    logic [PW-1:0]       s_waddr;
    t_pstat              s_wdata;

    assign pid_ext = {{PW{1'b0}}, r_pid};
    assign pid_idx = pid_ext[PW-1:0];
    assign pid_ok  = 32'(r_pid) < 32'(PROCS);

    // A unit size of zero divides as one.
    assign divisor  = (i_unit_bytes == '0) ? UB_W'(1) : i_unit_bytes;
    assign div_sh   = {r_rem, r_dvd[BYTES_W-1]};
    assign div_ge   = div_sh >= {1'b0, divisor};
    assign div_diff = div_sh - {1'b0, divisor};

    // Run tracking over the bitmap, one unit per cycle.
    assign rd_free   = !r_rd_q[PID_W];
    assign rd_last   = r_rd_idx == AW'(UNITS - 1);
    assign len_now   = rd_free ? r_cur_len + LW'(1) : r_cur_len;
    assign start_now = (rd_free && r_cur_len == '0) ? r_rd_idx : r_cur_start;
    assign run_close = !rd_free || rd_last;
    assign run_fits  = (len_now != '0) && (len_now >= r_need) && (len_now < r_best_len);
    assign sweep_hit = i_cmd.sweep_en && r_rd_vld && !rd_free && (r_rd_q[PID_W-1:0] == r_pid);

    assign clr_unit = i_cmd.clr_step && (32'(r_clr) < 32'(UNITS));
    assign clr_proc = i_cmd.clr_step && (32'(r_clr) < 32'(PROCS));

    always_comb begin
        u_we    = 1'b0;
        u_waddr = r_waddr;
        u_wdata = {1'b1, r_pid};
        if (clr_unit) begin
            u_we    = 1'b1;
            u_waddr = r_clr[AW-1:0];
            u_wdata = '0;
        end else if (i_cmd.mark_step) begin
            u_we = 1'b1;
        end else if (sweep_hit) begin
            u_we    = 1'b1;
            u_waddr = r_rd_idx;
            u_wdata = {1'b0, r_pid};
        end
    end

    always_comb begin
        s_we    = i_cmd.stat_we;
        s_waddr = pid_idx;
        s_wdata = i_cmd.stat_val;
        if (clr_proc) begin
            s_we    = 1'b1;
            s_waddr = r_clr[PW-1:0];
            s_wdata = ST_PENDING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            r_umem[u_waddr] <= u_wdata;
        end
        r_rd_q <= r_umem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_waddr] <= s_wdata;
        end
        r_stat_q <= r_smem[pid_idx];
    end

    // Control counters and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_iss    <= 1'b0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
            r_dcnt   <= '0;
            r_k      <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + CLW'(1);
            end
            if (i_cmd.div_init) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            if (i_cmd.pass_init) begin
                r_addr <= '0;
                r_iss  <= 1'b1;
            end else if (r_iss) begin
                r_addr <= r_addr + AW'(1);
                if (r_addr == AW'(UNITS - 1)) begin
                    r_iss <= 1'b0;
                end
            end
            r_rd_vld <= r_iss;
            if (i_cmd.take_fit) begin
                r_k <= LW'(1);
            end else if (i_cmd.mark_step) begin
                r_k <= r_k + LW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_pid   <= i_process_id;
            r_dvd   <= i_request_bytes;
            r_start <= '0;
            r_count <= '0;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[UB_W-1:0] : div_sh[UB_W-1:0];
            r_dvd <= {r_dvd[BYTES_W-2:0], div_ge};
        end
        if (i_cmd.pass_init) begin
            r_too_big   <= 32'(r_dvd) > 32'(UNITS);
            r_need      <= r_dvd[LW-1:0];
            r_cur_len   <= '0;
            r_cur_start <= '0;
            r_best_len  <= LW'(UNITS + 1);
            r_best_start <= '0;
            r_found     <= 1'b0;
        end else if (i_cmd.scan_en && r_rd_vld) begin
            r_cur_len   <= run_close ? '0 : len_now;
            r_cur_start <= start_now;
            if (run_close && run_fits) begin
                r_best_len   <= len_now;
                r_best_start <= start_now;
                r_found      <= 1'b1;
            end
        end
        if (sweep_hit) begin
            r_count <= r_count + LW'(1);
        end
        if (i_cmd.take_fit) begin
            r_start <= r_best_start;
            r_count <= r_need;
            r_waddr <= r_best_start;
        end else if (i_cmd.mark_step) begin
            r_waddr <= r_waddr + AW'(1);
        end
        if (i_cmd.code_we) begin
            r_code <= i_cmd.code;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = r_clr == CLW'(CLR_N - 1);
        o_sts.op        = r_op;
        o_sts.pid_ok    = pid_ok;
        o_sts.stat      = r_stat_q;
        o_sts.div_last  = r_dcnt == DCNT_W'(DIV_STEPS - 1);
        // The quotient has settled in the dividend register after the last step.
        o_sts.too_big   = 32'(r_dvd) > 32'(UNITS);
        o_sts.pass_last = r_rd_vld && rd_last;
        o_sts.found     = r_found && !r_too_big;
        o_sts.need_zero = r_need == '0;
        o_sts.mark_last = r_k == r_count;
    end

    assign o_result_code = r_code;
    assign o_start_unit  = START_W'(r_start);
    assign o_unit_count  = COUNT_W'(r_count);

endmodule

[rtl/best_fit_unit_allocator.sv]
// Best-fit allocator over a bitmap of UNITS memory units for PROCS processes.
// A request is taken when start is high and busy is low; its one result beat
// appears on the result ports for a single cycle with o_done high, and it
// must be captured then. An allocate first divides the request size by
// unit_bytes bit-serially, then makes one pass over the unit memory to find
// the best hole (one unit per cycle through its single read port), then
// marks the units granted one after another. A deallocate makes its own
// pass over the unit memory, and a request rejected on process status is
// answered without a pass. After reset, busy stays high while the unit and
// status memories are cleared; unit_bytes may be written meanwhile.
module best_fit_unit_allocator #(
    parameter int UNITS = 64,
    parameter int PROCS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfa_pkg::ADDR_W-1:0]    paddr,
    input  logic [bfa_pkg::DATA_W-1:0]    pwdata,
    output logic [bfa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  bfa_pkg::t_op                  i_operation,
    input  logic [bfa_pkg::PID_W-1:0]     i_process_id,
    input  logic [bfa_pkg::BYTES_W-1:0]   i_request_bytes,
    output logic                          o_done,
    output bfa_pkg::t_code                o_result_code,
    output logic [bfa_pkg::START_W-1:0]   o_start_unit,
    output logic [bfa_pkg::COUNT_W-1:0]   o_unit_count
);
    import bfa_pkg::*;

    logic [UB_W-1:0] r_unit_bytes;
    t_cmd            cmd;
    t_sts            sts;
    logic            reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1] == REG_UNIT_BYTES;
    assign prdata  = reg_sel ? DATA_W'(r_unit_bytes) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_bytes <= UB_W'(1);
        end else if (psel && penable && pwrite && reg_sel) begin
            r_unit_bytes <= pwdata[UB_W-1:0];
        end
    end

    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bfa_dp #(
        .UNITS (UNITS),
        .PROCS (PROCS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_unit_bytes    (r_unit_bytes),
        .i_operation     (i_operation),
        .i_process_id    (i_process_id),
        .i_request_bytes (i_request_bytes),
        .o_result_code   (o_result_code),
        .o_start_unit    (o_start_unit),
        .o_unit_count    (o_unit_count)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat shown while the block reports idle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result_code != RC_DONE) |-> (o_start_unit == '0 && o_unit_count == '0))
        else $error("failed request reports a nonzero start or count");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result_code == RC_DONE || o_result_code == RC_NOFIT ||
                    o_result_code == RC_STATUS))
        else $error("result beat carries an undefined code");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not hold the block busy");

endmodule

[dv/best_fit_unit_allocator_test.sv]
`timescale 1ns / 100ps

module best_fit_unit_allocator_test;
    import bfa_pkg::*;

    localparam int UNITS           = 64;
    localparam int PROCS           = 16;
    localparam int IDLE_LIMIT      = 5000;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES   = 200;

    localparam logic [ADDR_W-1:0] UNIT_BYTES_ADDR = {REG_UNIT_BYTES, 2'b00};
    // First word past the register map; writes there must have no effect.
    localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

    typedef struct packed {
        t_code              code;
        logic [START_W-1:0] first_unit;
        logic [COUNT_W-1:0] units;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [UB_W-1:0]  unit_bytes;
        bit               unit_used [UNITS];
        logic [PID_W-1:0] unit_owner [UNITS];
        t_pstat           proc_state [PROCS];
        t_alloc_result    expected_q [$];
        int               failures;

        function new();
            unit_bytes = 1;
            failures   = 0;
            foreach (unit_used[i]) begin
                unit_used[i]  = 1'b0;
                unit_owner[i] = '0;
            end
            foreach (proc_state[p]) begin
                proc_state[p] = ST_PENDING;
            end
        endfunction

        function void set_unit_bytes(logic [DATA_W-1:0] value);
            unit_bytes = value[UB_W-1:0];
        endfunction

        // A unit size of zero divides like a unit size of one.
        function int divisor();
            return (unit_bytes == 0) ? 1 : int'(unit_bytes);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function int largest_hole();
            int run;
            int longest;
            run     = 0;
            longest = 0;
            foreach (unit_used[i]) begin
                run = unit_used[i] ? 0 : run + 1;
                if (run > longest) begin
                    longest = run;
                end
            end
            return longest;
        endfunction

        // Smallest maximal free run of at least need units, earliest on a tie.
        function bit best_hole(int need, output int first);
            int best_len;
            int i;
            int j;
            bit found;
            best_len = UNITS + 1;
            found    = 1'b0;
            first    = 0;
            i        = 0;
            while (i < UNITS) begin
                if (unit_used[i]) begin
                    i++;
                end else begin
                    j = i;
                    while (j < UNITS && !unit_used[j]) begin
                        j++;
                    end
                    if (j - i < best_len && j - i >= need) begin
                        best_len = j - i;
                        first    = i;
                        found    = 1'b1;
                    end
                    i = j;
                end
            end
            return found;
        endfunction

        function void note_request(t_op op, logic [PID_W-1:0] pid,
                                   logic [BYTES_W-1:0] bytes);
            t_alloc_result r;
            int need;
            int first;
            int k;
            int freed;
            r.code       = RC_STATUS;
            r.first_unit = '0;
            r.units      = '0;
            if (op == OP_ALLOC) begin
                if (proc_state[pid] == ST_PENDING) begin
                    need = int'(bytes) / divisor();
                    if (need <= UNITS && best_hole(need, first)) begin
                        for (k = 0; k < need; k++) begin
                            unit_used[first + k]  = 1'b1;
                            unit_owner[first + k] = pid;
                        end
                        proc_state[pid] = ST_ALLOCATED;
                        r.code       = RC_DONE;
                        r.first_unit = START_W'(first);
                        r.units      = COUNT_W'(need);
                    end else begin
                        r.code = RC_NOFIT;
                    end
                end
            end else if (proc_state[pid] == ST_ALLOCATED) begin
                freed = 0;
                for (k = 0; k < UNITS; k++) begin
                    if (unit_used[k] && unit_owner[k] == pid) begin
                        unit_used[k] = 1'b0;
                        freed++;
                    end
                end
                proc_state[pid] = ST_FINISHED;
                r.code  = RC_DONE;
                r.units = COUNT_W'(freed);
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_code code, logic [START_W-1:0] first_unit,
                                   logic [COUNT_W-1:0] units);
            t_alloc_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result beat with no request outstanding: code %0d start %0d count %0d",
                       code, first_unit, units);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (code !== exp_r.code) begin
                $error("result_code: expected %0d, actual %0d", exp_r.code, code);
                failures++;
            end
            if (first_unit !== exp_r.first_unit) begin
                $error("start_unit: expected %0d, actual %0d", exp_r.first_unit, first_unit);
                failures++;
            end
            if (units !== exp_r.units) begin
                $error("unit_count: expected %0d, actual %0d", exp_r.units, units);
                failures++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    t_op                  i_operation;
    logic [PID_W-1:0]     i_process_id;
    logic [BYTES_W-1:0]   i_request_bytes;
    logic                 o_done;
    t_code                o_result_code;
    logic [START_W-1:0]   o_start_unit;
    logic [COUNT_W-1:0]   o_unit_count;

    alloc_scoreboard alloc_sb = new();
    int idle_cycles = 0;

    best_fit_unit_allocator #(
        .UNITS(UNITS),
        .PROCS(PROCS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_process_id   (i_process_id),
        .i_request_bytes(i_request_bytes),
        .o_done         (o_done),
        .o_result_code  (o_result_code),
        .o_start_unit   (o_start_unit),
        .o_unit_count   (o_unit_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result capture and the stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                alloc_sb.check_result(o_result_code, o_start_unit, o_unit_count);
            end
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL best_fit_unit_allocator");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12) begin
            return 0;
        end
        if (roll < 18) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 120);
    endfunction

    task automatic reg_access(bit is_write, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (is_write && addr == UNIT_BYTES_ADDR) begin
            alloc_sb.set_unit_bytes(data);
        end
        if (!is_write && addr == UNIT_BYTES_ADDR &&
            prdata[UB_W-1:0] !== alloc_sb.unit_bytes) begin
            $error("unit_bytes: expected %0d, actual %0d",
                   alloc_sb.unit_bytes, prdata[UB_W-1:0]);
            alloc_sb.failures++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(t_op op, logic [PID_W-1:0] pid,
                                logic [BYTES_W-1:0] bytes);
        int gap;
        @(negedge i_clk);
        start           <= 1'b1;
        i_operation     <= op;
        i_process_id    <= pid;
        i_request_bytes <= bytes;
        do @(posedge i_clk); while (busy);
        alloc_sb.note_request(op, pid, bytes);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Holds off new requests until every outstanding beat has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (alloc_sb.outstanding() != 0 || busy);
    endtask

    // Sizes are mostly just past the largest hole, so that most allocations
    // fail and keep the process pending for later scans.
    task automatic random_request();
        t_op                op;
        logic [PID_W-1:0]   pid;
        logic [BYTES_W-1:0] bytes;
        int                 roll;
        int                 need;
        int                 bytes_int;
        op    = ($urandom_range(0, 9) < 6) ? OP_ALLOC : OP_FREE;
        pid   = PID_W'($urandom_range(0, PROCS - 1));
        bytes = BYTES_W'($urandom);
        roll  = $urandom_range(0, 15);
        if (op == OP_ALLOC && roll < 10) begin
            if (roll == 0) begin
                need = $urandom_range(0, alloc_sb.largest_hole());
            end else begin
                need = alloc_sb.largest_hole() + 1 + $urandom_range(0, 8);
            end
            bytes_int = need * alloc_sb.divisor() +
                        $urandom_range(0, alloc_sb.divisor() - 1);
            bytes = (bytes_int > 65535) ? '1 : BYTES_W'(bytes_int);
        end
        send_request(op, pid, bytes);
    endtask

    initial begin
        logic [DATA_W-1:0] ub_settings [6];
        ub_settings = '{32'd0, 32'hFFFF_E003, 32'd1, 32'd0, 32'd4096, 32'd8191};
        ub_settings[3] = $urandom_range(2, 64);

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        i_operation     = OP_ALLOC;
        i_process_id    = '0;
        i_request_bytes = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The write lands while the memories are still being cleared.
        reg_access(1'b1, UNIT_BYTES_ADDR, 32'd1);

        send_request(OP_ALLOC, 4'd9, 16'd64);
        send_request(OP_FREE,  4'd9, 16'hFFFF);
        send_request(OP_ALLOC, 4'd0, 16'd10);
        send_request(OP_ALLOC, 4'd1, 16'd26);
        send_request(OP_ALLOC, 4'd2, 16'd2);
        send_request(OP_FREE,  4'd1, 16'd0);
        // Two holes of equal length: the earlier one must be taken.
        send_request(OP_ALLOC, 4'd3, 16'd20);
        send_request(OP_ALLOC, 4'd4, 16'd5);
        // A zero-unit request lands on the single-unit hole.
        send_request(OP_ALLOC, 4'd5, 16'd0);
        send_request(OP_FREE,  4'd5, 16'd0);
        send_request(OP_ALLOC, 4'd5, 16'd1);
        send_request(OP_FREE,  4'd5, 16'd0);
        send_request(OP_FREE,  4'd6, 16'd0);
        send_request(OP_ALLOC, 4'd2, 16'd1);
        send_request(OP_ALLOC, 4'd6, 16'hFFFF);
        send_request(OP_ALLOC, 4'd6, 16'd27);
        send_request(OP_ALLOC, 4'd6, 16'd26);
        send_request(OP_ALLOC, 4'd7, 16'd2);
        send_request(OP_ALLOC, 4'd7, 16'd1);
        // Nothing is free now, so even a zero-unit request fails.
        send_request(OP_ALLOC, 4'd8, 16'd0);
        send_request(OP_FREE,  4'd0, 16'd0);
        wait_drained();

        foreach (ub_settings[s]) begin
            wait_drained();
            reg_access(1'b1, UNIT_BYTES_ADDR, ub_settings[s]);
            if (s == 0) begin
                reg_access(1'b1, SPARE_ADDR, $urandom);
            end
            reg_access(1'b0, UNIT_BYTES_ADDR, '0);
            repeat (ITEMS_PER_PHASE) begin
                random_request();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (alloc_sb.outstanding() != 0) begin
            $error("%0d result beats never arrived", alloc_sb.outstanding());
        end
        if (alloc_sb.failures == 0 && alloc_sb.outstanding() == 0) begin
            $display("PASS best_fit_unit_allocator");
        end else begin
            $display("FAIL best_fit_unit_allocator");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_dp.sv
rtl/best_fit_unit_allocator.sv
dv/best_fit_unit_allocator_test.sv
